>>> src/particle_shape_motion_step_core_defines.svh
// Assertion macros for the particle shape motion step core.
// Included by RTL files that carry concurrent assertions.
`ifndef PARTICLE_SHAPE_MOTION_STEP_CORE_DEFINES_SVH
`define PARTICLE_SHAPE_MOTION_STEP_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PSM_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define PSM_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PSM_ASSERT_IMP(label, clk, rst_n, a, c)
`define PSM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> src/psm_pkg.sv
// Shared types, constants and arithmetic helpers of the particle shape core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;
  localparam int MAX_POINTS   = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int STEP_W       = 5;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] REG_SCALE   = 2'd0;
  localparam logic [1:0] REG_GRAVITY = 2'd1;
  localparam logic [1:0] REG_TTL     = 2'd2;
  localparam logic [1:0] REG_COUNT   = 2'd3;

  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032875;

  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [19:0] vel_x;
    logic signed [19:0] vel_y;
    logic [17:0]        spin_rate;
    logic [15:0]        time_step;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] center_x_out;
    logic signed [23:0] center_y_out;
    logic signed [23:0] life_left;
    logic               is_last;
  } out_word_t;

  function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0: r = 34'sd843314857;  5'd1: r = 34'sd497837830;
      5'd2: r = 34'sd263043837;  5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021688;   5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;   5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;    5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048576;   5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;    5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;     5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;     5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;       5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7fffff;
    if (v < -48'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction
endpackage
`default_nettype wire

>>> src/psm_cordic.sv
// Iterative CORDIC, rotation mode, one micro-rotation per cycle.
// Depends on psm_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_shape_motion_step_core_defines.svh"
module psm_cordic import psm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [33:0] angle,
  output logic                    done,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);
  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r, busy_r, done_r;
  logic [STEP_W-1:0]  i_r;
  logic signed [33:0] z0;

  assign z0 = (angle > HALF_PI_Q30) ? angle - PI_Q30 : angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        x_r <= GAIN_Q30; y_r <= '0; z_r <= z0; i_r <= '0;
        flip_r <= angle > HALF_PI_Q30;
      end else if (busy_r) begin
        if (!z_r[33]) begin
          x_r <= x_r - (y_r >>> i_r); y_r <= y_r + (x_r >>> i_r);
          z_r <= z_r - atan_q30(i_r);
        end else begin
          x_r <= x_r + (y_r >>> i_r); y_r <= y_r - (x_r >>> i_r);
          z_r <= z_r + atan_q30(i_r);
        end
        i_r <= i_r + 1'b1;
        if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

  `PSM_ASSERT_NXT(a_cordic_done, clk, rst_n, done_r, !busy_r)
  `PSM_ASSERT_IMP(a_cordic_idle, clk, rst_n, done_r, !start)
  `PSM_ASSERT_IMP(a_cordic_step, clk, rst_n, busy_r, i_r < STEP_W'(CORDIC_STEPS))
endmodule
`default_nettype wire

>>> src/particle_shape_motion_step_core.sv
// Top level of the particle shape motion core: vertex memory, tick sequencer.
// Depends on psm_pkg and psm_cordic.
`timescale 1ns / 1ps
`default_nettype none
`include "particle_shape_motion_step_core_defines.svh"
// One polygonal particle. Start and load words are handled as they are
// accepted and leave the core idle. A tick word starts the shared CORDIC as
// it is accepted. The sequencer then waits in S_CORD for its done
// (CORDIC_STEPS micro-rotations) and computes the motion terms in S_MOT1 to
// S_MOT3. After that it walks the vertex memory one vertex at a time through
// a single read port: registered read, centre subtract, four 34x25
// multiplies for the rotation, round, scale, then the output register is
// loaded and the vertex is written back. No input word is taken until the
// tick is done. The walk pauses while a result word waits in the output
// register. The last word of a tick does not hold up the next input word.
// Vertex memory has no reset; only loaded slots may be ticked.
module particle_shape_motion_step_core import psm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [23:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_CORD, S_MOT1, S_MOT2, S_MOT3, S_RD, S_MUL, S_SUM, S_SCL, S_WR, S_OUT
  } state_t;

  state_t state_r;
  logic [16:0] scale_r;
  logic [17:0] grav_r;
  logic [23:0] ttl_r;
  logic [CNT_W-1:0] pcnt_r;

  logic signed [23:0] cx_r, cy_r, ncx_r, ncy_r, life_r;
  logic signed [19:0] sx_r, sy_r;
  logic [17:0] spin_r;
  logic [15:0] dt_r;
  logic signed [47:0] mx_r, my_r;
  logic [CNT_W-1:0] cnt_r, k_r;

  // vertex memory, one entry holds x and y
  logic [47:0] mem [MAX_POINTS];
  logic [47:0] rd_r;
  logic        we;
  logic [IDX_W-1:0] wa;
  logic [47:0] wd;

  logic signed [33:0] cs, sn;
  logic cord_done, cord_start;
  logic signed [33:0] angle;

  logic signed [24:0] dx_r, dy_r;
  logic signed [63:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [35:0] rx_r, ry_r;
  logic signed [53:0] scx_r, scy_r;
  logic signed [47:0] prod_r;
  out_word_t ob_r;
  logic ov_r;

  psm_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_start), .angle(angle),
    .done(cord_done), .cos_o(cs), .sin_o(sn)
  );

  // angle is taken from the tick word itself, CORDIC starts at acceptance
  logic signed [35:0] ang_prod;
  assign ang_prod = $signed({1'b0, in_data.time_step}) * $signed({1'b0, spin_r});
  // round(dt*spin / 2^16) widened to Q.30
  assign angle = 34'((ang_prod + 36'sd32768) >>> 16) <<< 14;
  assign cord_start = (state_r == S_IDLE) && in_valid && in_ready &&
                      in_data.action == ACT_TICK;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = ob_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[k_r[IDX_W-1:0]];
  end

  logic signed [47:0] vxn, vyn;
  assign vxn = 48'(cx_r) + 48'((scx_r + 54'sd32768) >>> 16) + mx_r;
  assign vyn = 48'(cy_r) + 48'((scy_r + 54'sd32768) >>> 16) + my_r;

  // vertex write-back goes with the output register load
  always_comb begin
    we = 1'b0; wa = k_r[IDX_W-1:0]; wd = {sat24(vxn), sat24(vyn)};
    if (state_r == S_IDLE && in_valid && in_ready && in_data.action == ACT_LOAD) begin
      we = 1'b1; wa = in_data.vertex_index; wd = {in_data.pos_x, in_data.pos_y};
    end else if (state_r == S_OUT && (!ov_r || out_ready)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
      scale_r <= 17'd65536; grav_r <= 18'd256000; ttl_r <= 24'd327680;
      pcnt_r <= 7'd64;
      cx_r <= '0; cy_r <= '0; sx_r <= '0; sy_r <= '0; spin_r <= '0; life_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SCALE:   scale_r <= cfg_data[16:0];
          REG_GRAVITY: grav_r  <= cfg_data[17:0];
          REG_TTL:     ttl_r   <= cfg_data;
          REG_COUNT:   pcnt_r  <= cfg_data[6:0];
        endcase
      end
      if (ov_r && out_ready && state_r != S_OUT) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          unique case (in_data.action)
            ACT_START: begin
              cx_r <= in_data.pos_x; cy_r <= in_data.pos_y;
              sx_r <= in_data.vel_x; sy_r <= in_data.vel_y;
              spin_r <= in_data.spin_rate;
              life_r <= ttl_r[23] ? 24'sh7fffff : ttl_r;
            end
            ACT_TICK: begin
              dt_r <= in_data.time_step;
              life_r <= sat24(48'(life_r) - 48'(in_data.time_step));
              cnt_r <= (pcnt_r > 7'd64) ? 7'd64 : pcnt_r;
              state_r <= S_CORD;
            end
            ACT_LOAD: ;
            default: ;
          endcase
        end
        S_CORD: if (cord_done) state_r <= S_MOT1;
        S_MOT1: begin
          prod_r <= $signed({1'b0, grav_r}) * $signed({1'b0, dt_r});
          mx_r <= (48'(sx_r) * $signed({1'b0, dt_r}) + 48'sd32768) >>> 16;
          state_r <= S_MOT2;
        end
        S_MOT2: begin
          sy_r <= 20'(sat24(48'(sy_r) - ((prod_r + 48'sd32768) >>> 16)) > 24'sd524287
                   ? 24'sd524287 : (sat24(48'(sy_r) - ((prod_r + 48'sd32768) >>> 16))
                   < -24'sd524288 ? -24'sd524288
                   : sat24(48'(sy_r) - ((prod_r + 48'sd32768) >>> 16))));
          state_r <= S_MOT3;
        end
        S_MOT3: begin
          my_r <= (48'(sy_r) * $signed({1'b0, dt_r}) + 48'sd32768) >>> 16;
          ncx_r <= sat24(48'(cx_r) + ((48'(sx_r) * $signed({1'b0, dt_r})
                   + 48'sd32768) >>> 16));
          ncy_r <= sat24(48'(cy_r) + ((48'(sy_r) * $signed({1'b0, dt_r})
                   + 48'sd32768) >>> 16));
          k_r <= '0;
          state_r <= (cnt_r == '0) ? S_IDLE : S_RD;
          if (cnt_r == '0) begin cx_r <= sat24(48'(cx_r) + mx_r); end
        end
        S_RD: state_r <= S_MUL;
        S_MUL: begin
          dx_r <= 25'($signed(rd_r[47:24])) - 25'(cx_r);
          dy_r <= 25'($signed(rd_r[23:0])) - 25'(cy_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          p1_r <= 64'(dx_r) * 64'(cs); p2_r <= 64'(dy_r) * 64'(sn);
          p3_r <= 64'(dx_r) * 64'(sn); p4_r <= 64'(dy_r) * 64'(cs);
          state_r <= S_SCL;
        end
        S_SCL: begin
          rx_r <= 36'((p1_r - p2_r + 64'sd536870912) >>> 30);
          ry_r <= 36'((p3_r + p4_r + 64'sd536870912) >>> 30);
          state_r <= S_WR;
        end
        // scale products settle here
        S_WR: state_r <= S_OUT;
        S_OUT: if (!ov_r || out_ready) begin
          ov_r <= 1'b1;
          ob_r.out_index <= k_r[IDX_W-1:0];
          ob_r.out_x <= sat24(vxn); ob_r.out_y <= sat24(vyn);
          ob_r.center_x_out <= ncx_r; ob_r.center_y_out <= ncy_r;
          ob_r.life_left <= life_r;
          ob_r.is_last <= (k_r == cnt_r - 1'b1);
          if (k_r == cnt_r - 1'b1) begin
            cx_r <= ncx_r; cy_r <= ncy_r; state_r <= S_IDLE;
          end else begin
            state_r <= S_RD;
          end
          k_r <= k_r + 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_MOT3 && cnt_r == '0) cy_r <= sat24(48'(cy_r) + ((48'(sy_r)
          * $signed({1'b0, dt_r}) + 48'sd32768) >>> 16));
    end
  end

  // scale products registered ahead of the write-back
  always_ff @(posedge clk) begin
    scx_r <= 54'(rx_r) * $signed({1'b0, scale_r});
    scy_r <= 54'(ry_r) * $signed({1'b0, scale_r});
  end

  `PSM_ASSERT_IMP(a_busy_no_in, clk, rst_n, state_r != S_IDLE, !in_ready)
  `PSM_ASSERT_IMP(a_wr_in_walk, clk, rst_n, state_r == S_WR, k_r < cnt_r)
  `PSM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

>>> tb/psm_motion_checker.sv
// Scoreboard for the particle shape motion core: tracks config, input and result words.
// Holds its own model of the particle and compares every result word with it.
// Depends on psm_pkg.
`timescale 1ns / 1ps
module psm_motion_checker import psm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          words_seen
);
  // model state, kept wide
  longint vx_mem [MAX_POINTS];
  longint vy_mem [MAX_POINTS];
  longint cx, cy, spd_x, spd_y, spin_q, life_q;
  longint scale_q, grav_q, ttl_q, npts_q;
  out_word_t motion_words[$];

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  task automatic rotate_angle(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    bit flip;
    longint atan_tab [24] = '{843314857, 497837830, 263043837, 133525159, 67021688,
                              33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                              524288, 262144, 131072, 65536, 32768, 16384, 8192,
                              4096, 2048, 1024, 512, 256, 128};
    x = GAIN_Q30;
    y = 0;
    z = ang;
    flip = 0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_tick(input longint dt);
    longint cs, sn, mx, my, ncx, ncy, dx, dy, rx, ry, sx, sy, cnt;
    out_word_t w;
    cnt = npts_q > MAX_POINTS ? MAX_POINTS : npts_q;
    life_q = clip(life_q - dt, 24);
    rotate_angle(round_shift(dt * spin_q, 16) * 16384, cs, sn);
    mx = round_shift(spd_x * dt, 16);
    spd_y = clip(spd_y - round_shift(grav_q * dt, 16), 20);
    my = round_shift(spd_y * dt, 16);
    ncx = clip(cx + mx, 24);
    ncy = clip(cy + my, 24);
    for (int k = 0; k < cnt; k++) begin
      dx = vx_mem[k] - cx;
      dy = vy_mem[k] - cy;
      rx = round_shift(dx * cs - dy * sn, 30);
      ry = round_shift(dx * sn + dy * cs, 30);
      sx = round_shift(rx * scale_q, 16);
      sy = round_shift(ry * scale_q, 16);
      vx_mem[k] = clip(cx + sx + mx, 24);
      vy_mem[k] = clip(cy + sy + my, 24);
      w.out_index    = k[5:0];
      w.out_x        = vx_mem[k][23:0];
      w.out_y        = vy_mem[k][23:0];
      w.center_x_out = ncx[23:0];
      w.center_y_out = ncy[23:0];
      w.life_left    = life_q[23:0];
      w.is_last      = (k == cnt - 1);
      motion_words.push_back(w);
    end
    cx = ncx;
    cy = ncy;
  endtask

  task automatic field_check(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      fail_count++;
    end
  endtask

  assign pending = motion_words.size();

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        vx_mem[i] = 0;
        vy_mem[i] = 0;
      end
      cx = 0; cy = 0; spd_x = 0; spd_y = 0; spin_q = 0; life_q = 0;
      scale_q = 65536; grav_q = 256000; ttl_q = 327680; npts_q = 64;
      motion_words.delete();
      fail_count = 0;
      words_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (motion_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          e = motion_words.pop_front();
          field_check("out_index", e.out_index, out_data.out_index);
          field_check("out_x", e.out_x, out_data.out_x);
          field_check("out_y", e.out_y, out_data.out_y);
          field_check("center_x_out", e.center_x_out, out_data.center_x_out);
          field_check("center_y_out", e.center_y_out, out_data.center_y_out);
          field_check("life_left", e.life_left, out_data.life_left);
          field_check("is_last", e.is_last, out_data.is_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCALE:   scale_q = cfg_data[16:0];
          REG_GRAVITY: grav_q  = cfg_data[17:0];
          REG_TTL:     ttl_q   = cfg_data[23:0];
          REG_COUNT:   npts_q  = cfg_data[6:0];
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.action)
          ACT_START: begin
            cx = in_data.pos_x; cy = in_data.pos_y;
            spd_x = in_data.vel_x; spd_y = in_data.vel_y;
            spin_q = in_data.spin_rate;
            life_q = clip(ttl_q, 24);
          end
          ACT_LOAD: begin
            vx_mem[in_data.vertex_index] = in_data.pos_x;
            vy_mem[in_data.vertex_index] = in_data.pos_y;
          end
          ACT_TICK: predict_tick(in_data.time_step);
          default: ;
        endcase
      end
    end
  end
endmodule

>>> tb/tb_top.sv
// Top of the particle shape motion testbench: clock, reset, stimulus and verdict.
// Drives particle_shape_motion_step_core; checking lives in psm_motion_checker.
`timescale 1ns / 1ps
module tb_top;
  import psm_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 300;   // worst tick with no result, plus slack

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_word_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  int fail_count, pending, words_seen;
  int cycles = 0;
  int send_idle = 0;       // percent of cycles the sender holds off
  int recv_idle = 0;       // percent of cycles the receiver holds off
  logic hold_off = 0;      // long receiver stall
  logic stall_go = 0;
  int ticks_sent = 0;
  int words_sent = 0;

  // vertex slots loaded so far, so a tick never reads an unwritten slot
  bit [MAX_POINTS-1:0] loaded = '0;
  int npts = 64;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  particle_shape_motion_step_core dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  psm_motion_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .words_seen
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random backpressure, forced low during a hold-off
  always @(posedge clk)
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);

  // one long stall so the core fills its output register and backs up the input
  initial begin
    wait (stall_go);
    @(posedge clk);
    hold_off <= 1;
    repeat (600) @(posedge clk);
    hold_off <= 0;
  end

  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (w.action == ACT_TICK) ticks_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // core is idle once every expected word is out and a tick with no
  // result has had time to finish; a clock edge goes first so the checker
  // has seen the last accepted word
  task automatic drain_core();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_word_t base_word(input logic [1:0] act);
    in_word_t w;
    w = '0;
    w.action       = act;
    w.vertex_index = 6'($urandom);
    w.pos_x        = 24'($urandom);
    w.pos_y        = 24'($urandom);
    w.vel_x        = 20'($urandom);
    w.vel_y        = 20'($urandom);
    w.spin_rate    = 18'($urandom);
    w.time_step    = 16'($urandom);
    return w;
  endfunction

  // mostly moderate coordinates, sometimes the full range
  function automatic logic [23:0] coord();
    if ($urandom_range(9) < 7) return 24'($signed($urandom_range(65535)) - 32768);
    return 24'($urandom);
  endfunction

  task automatic send_load(input int idx, input logic [23:0] x, input logic [23:0] y);
    in_word_t w;
    w = base_word(ACT_LOAD);
    w.vertex_index = 6'(idx);
    w.pos_x = x;
    w.pos_y = y;
    send_word(w);
    loaded[idx] = 1;
  endtask

  // loads any slot in use that is still unwritten, then ticks
  task automatic send_tick(input logic [15:0] dt);
    in_word_t w;
    int lim;
    lim = npts > MAX_POINTS ? MAX_POINTS : npts;
    for (int i = 0; i < lim; i++)
      if (!loaded[i]) send_load(i, coord(), coord());
    w = base_word(ACT_TICK);
    w.time_step = dt;
    send_word(w);
  endtask

  task automatic set_regs(input int sc, input int gr, input int ttl, input int cnt);
    write_reg(REG_SCALE, 24'(sc));
    write_reg(REG_GRAVITY, 24'(gr));
    write_reg(REG_TTL, 24'(ttl));
    write_reg(REG_COUNT, 24'(cnt));
    npts = cnt;
  endtask

  task automatic random_items(input int n);
    in_word_t w;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        w = base_word(ACT_START);
        w.pos_x = coord();
        w.pos_y = coord();
        if ($urandom_range(3) != 0) w.spin_rate = 18'($urandom_range(205887));
        send_word(w);
      end else if (pick < 50) begin
        send_load($urandom_range(MAX_POINTS - 1), coord(), coord());
      end else if (pick < 95) begin
        send_tick(16'($urandom));
      end else begin
        // undefined action: no effect, no result
        w = base_word(2'd3);
        send_word(w);
      end
    end
  endtask

  initial begin
    in_word_t w;
    int sc_tab  [5] = '{65536, 131071, 0, 70000, 60000};
    int gr_tab  [5] = '{256000, 262143, 0, 1000, 128};
    int ttl_tab [5] = '{327680, 16777215, 0, 100000, 5000000};
    // phase 2 has no vertices in use, phase 3 asks for more than the store holds
    int cnt_tab [5] = '{3, 64, 0, 100, 7};

    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, every action, the edge cases
    send_idle = 13;
    recv_idle = 47;
    set_regs(sc_tab[0], gr_tab[0], ttl_tab[0], cnt_tab[0]);
    w = base_word(ACT_START);
    w.pos_x = 24'h7fffff; w.pos_y = 24'h800000;
    w.vel_x = 20'h7ffff;  w.vel_y = 20'h80000;
    w.spin_rate = 18'h3ffff;
    send_word(w);
    send_load(0, 24'h7fffff, 24'h7fffff);
    send_load(1, 24'h800000, 24'h800000);
    send_load(2, 24'h000000, 24'hffffff);
    send_tick(16'hffff);
    send_tick(16'h0000);
    w = base_word(2'd3);
    send_word(w);
    w = base_word(ACT_START);
    w.pos_x = '0; w.pos_y = '0; w.vel_x = 20'h80000; w.vel_y = 20'h7ffff;
    w.spin_rate = 18'd205887;
    send_word(w);
    send_load(63, 24'h123456, 24'hedcba9);
    send_tick(16'h8000);
    w = base_word(ACT_START);
    w.pos_x = 24'h000100; w.pos_y = 24'hffff00; w.vel_x = '0; w.vel_y = '0;
    w.spin_rate = '0;
    send_word(w);
    send_tick(16'h0001);

    for (int p = 0; p < 5; p++) begin
      drain_core();
      send_idle = (p < 2) ? 13 : (p < 4) ? 47 : 0;
      recv_idle = (p < 2) ? 47 : (p < 4) ? 13 : 0;
      set_regs(sc_tab[p], gr_tab[p], ttl_tab[p], cnt_tab[p]);
      if (p == 1) stall_go <= 1;
      random_items(20);
    end

    drain_core();
    $display("sent %0d input words (%0d ticks) over five register settings", words_sent,
             ticks_sent);
    $display("checked %0d result words with several idle and stall patterns", words_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> particle_shape_motion_step_core.f
+incdir+src
src/psm_pkg.sv
src/psm_cordic.sv
src/particle_shape_motion_step_core.sv
tb/psm_motion_checker.sv
tb/tb_top.sv
